FILE: hw/rtl/lsats_pkg.sv
// ----------------------------------------------------------------------------
// lsats_pkg
// shared constants and types of the lip set-associative tag store
// ----------------------------------------------------------------------------
package lsats_pkg;

    // default geometry
    localparam int WAYS_DEF        = 8;
    localparam int SET_BITS_DEF    = 6;
    localparam int OFFSET_BITS_DEF = 6;
    localparam int ADDR_BITS_DEF   = 32;

    // field widths
    localparam int ADDR_W   = 32;
    localparam int WAY_W    = 3;
    localparam int REUSE_W  = 4;
    localparam int CNT_W    = 32;
    localparam int HIST_N   = 16;

    localparam logic [REUSE_W-1:0] REUSE_MAX = 4'd15;

    // result word: hit, way, victim_was_valid, victim_reuse, three totals
    localparam int RES_BITS = 1 + WAY_W + 1 + REUSE_W + 3 * CNT_W;
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

    // control from the back part to the front part
    typedef struct packed {
        logic pop;
        logic clr_busy;
    } t_q_ctl;

endpackage

FILE: hw/rtl/lsats_front.sv
// ----------------------------------------------------------------------------
// lsats_front
// accepts access words, splits the address into set and tag, queues them
// ----------------------------------------------------------------------------
module lsats_front import lsats_pkg::*; #(
    parameter int SET_BITS    = SET_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int TAG_W       = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [ADDR_W-1:0]   i_s_tdata,   // address
    input  t_q_ctl              i_ctl,
    output logic                o_q_valid,
    output logic [SET_BITS-1:0] o_q_set,
    output logic [TAG_W-1:0]    o_q_tag
);

    localparam int AEFF = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

    logic [63:0]         w_addr;
    logic [63:0]         w_line;
    logic [63:0]         w_tag_full;
    logic                w_push;

    // two-entry queue
    logic [SET_BITS-1:0] r_set [2];
    logic [TAG_W-1:0]    r_tag [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;

    // address split
    assign w_addr     = 64'(i_s_tdata) & ((64'd1 << AEFF) - 64'd1);
    assign w_line     = w_addr >> OFFSET_BITS;
    assign w_tag_full = w_line >> SET_BITS;

    assign o_s_tready = (r_cnt != 2'd2) && !i_ctl.clr_busy;
    assign w_push     = i_s_tvalid && o_s_tready;

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_set   = r_set[r_rp];
    assign o_q_tag   = r_tag[r_rp];

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_ctl.pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_ctl.pop);
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_set[r_wp] <= w_line[SET_BITS-1:0];
            r_tag[r_wp] <= w_tag_full[TAG_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/lsats_back.sv
// ----------------------------------------------------------------------------
// lsats_back
// set read-modify-write: lookup, lip replacement, counters, result register
// ----------------------------------------------------------------------------
module lsats_back import lsats_pkg::*; #(
    parameter int WAYS     = WAYS_DEF,
    parameter int SET_BITS = SET_BITS_DEF,
    parameter int TAG_W    = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  logic [SET_BITS-1:0] i_q_set,
    input  logic [TAG_W-1:0]    i_q_tag,
    output t_q_ctl              o_ctl,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [RES_W-1:0]    o_m_tdata
);

    localparam int SETS   = 1 << SET_BITS;
    localparam int WAYW   = $clog2(WAYS);
    localparam logic [WAYW-1:0] LRU = WAYW'(WAYS - 1);

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_UPD} t_state;

    // set rows
    logic [WAYS-1:0][TAG_W-1:0]   mem_tag   [SETS];
    logic [WAYS-1:0][WAYW-1:0]    mem_age   [SETS];
    logic [WAYS-1:0][REUSE_W-1:0] mem_reuse [SETS];
    logic [WAYS-1:0]              mem_valid [SETS];
    logic                         mem_full  [SETS];

    t_state                       r_state;
    logic [SET_BITS-1:0]          r_clr_idx;
    logic [SET_BITS-1:0]          r_set;
    logic [TAG_W-1:0]             r_tag;
    logic [WAYS-1:0][TAG_W-1:0]   r_rd_tag;
    logic [WAYS-1:0][WAYW-1:0]    r_rd_age;
    logic [WAYS-1:0][REUSE_W-1:0] r_rd_reuse;
    logic [WAYS-1:0]              r_rd_valid;
    logic                         r_rd_full;
    logic [CNT_W-1:0]             r_hist [HIST_N];
    logic [CNT_W-1:0]             r_hit_cnt;
    logic [CNT_W-1:0]             r_miss_cnt;
    logic                         r_ovalid;
    logic [RES_W-1:0]             r_odata;

    logic                         w_rd;
    logic                         w_done;
    logic [WAYS-1:0]              w_match;
    logic                         w_hit;
    logic [WAYW-1:0]              w_hidx;
    logic [WAYW-1:0]              w_vidx;
    logic [WAYW-1:0]              w_way;
    logic                         w_vvalid;
    logic [REUSE_W-1:0]           w_vreuse;
    logic [CNT_W-1:0]             w_btotal;
    logic [CNT_W-1:0]             n_hit_cnt;
    logic [CNT_W-1:0]             n_miss_cnt;
    logic [WAYS-1:0][TAG_W-1:0]   n_tag;
    logic [WAYS-1:0][WAYW-1:0]    n_age;
    logic [WAYS-1:0][REUSE_W-1:0] n_reuse;
    logic [WAYS-1:0]              n_valid;
    logic                         n_full;

    assign w_rd   = (r_state == S_IDLE) && i_q_valid;
    assign w_done = (r_state == S_UPD) && (!r_ovalid || i_m_tready);

    assign o_ctl.pop      = w_rd;
    assign o_ctl.clr_busy = (r_state == S_CLR);
    assign o_m_tvalid     = r_ovalid;
    assign o_m_tdata      = r_odata;

    // tag compare and first-hit / victim search
    always_comb begin
        w_hidx = '0;
        w_vidx = '0;
        for (int w = 0; w < WAYS; w++) begin
            w_match[w] = r_rd_valid[w] && (r_rd_tag[w] == r_tag);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                w_hidx = WAYW'(w);
            end
            if (!r_rd_valid[w] || (r_rd_age[w] == LRU)) begin
                w_vidx = WAYW'(w);
            end
        end
        w_hit = |w_match;
    end

    // row update
    always_comb begin
        n_tag      = r_rd_tag;
        n_age      = r_rd_age;
        n_reuse    = r_rd_reuse;
        n_valid    = r_rd_valid;
        n_full     = r_rd_full;
        w_vvalid   = 1'b0;
        w_vreuse   = '0;
        w_way      = w_hidx;
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (w_hit) begin
            n_hit_cnt = r_hit_cnt + CNT_W'(1);
            for (int w = 0; w < WAYS; w++) begin
                if ((WAYW'(w) != w_hidx) && r_rd_valid[w]
                        && (r_rd_age[w] < r_rd_age[w_hidx]) && (r_rd_age[w] < LRU)) begin
                    n_age[w] = r_rd_age[w] + WAYW'(1);
                end
            end
            n_age[w_hidx] = '0;
            if (r_rd_reuse[w_hidx] < REUSE_MAX) begin
                n_reuse[w_hidx] = r_rd_reuse[w_hidx] + REUSE_W'(1);
            end
        end else begin
            n_miss_cnt      = r_miss_cnt + CNT_W'(1);
            w_way           = w_vidx;
            w_vvalid        = r_rd_valid[w_vidx];
            w_vreuse        = w_vvalid ? r_rd_reuse[w_vidx] : '0;
            n_reuse[w_vidx] = '0;
            n_tag[w_vidx]   = r_tag;
            n_valid[w_vidx] = 1'b1;
            if (!r_rd_full) begin
                // filling: new line at mru, the others age
                for (int w = 0; w < WAYS; w++) begin
                    if ((WAYW'(w) != w_vidx) && r_rd_valid[w] && (r_rd_age[w] < LRU)) begin
                        n_age[w] = r_rd_age[w] + WAYW'(1);
                    end
                end
                n_age[w_vidx] = '0;
                n_full        = &n_valid;
            end else begin
                n_age[w_vidx] = LRU;
            end
        end
        w_btotal = w_vvalid ? (r_hist[w_vreuse] + CNT_W'(1)) : '0;
    end

    // sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_idx  <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_ovalid   <= 1'b0;
            for (int b = 0; b < HIST_N; b++) begin
                r_hist[b] <= '0;
            end
        end else begin
            if (r_ovalid && i_m_tready && !w_done) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + SET_BITS'(1);
                    if (&r_clr_idx) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_rd) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_done) begin
                        r_state    <= S_IDLE;
                        r_hit_cnt  <= n_hit_cnt;
                        r_miss_cnt <= n_miss_cnt;
                        r_ovalid   <= 1'b1;
                        if (w_vvalid) begin
                            r_hist[w_vreuse] <= w_btotal;
                        end
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_odata <= RES_W'({n_miss_cnt, n_hit_cnt, w_btotal, w_vreuse, w_vvalid,
                               WAY_W'(w_way), w_hit});
        end
    end

    // set row memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            mem_valid[r_clr_idx] <= '0;
            mem_reuse[r_clr_idx] <= '0;
            mem_full[r_clr_idx]  <= 1'b0;
        end else if (w_done) begin
            mem_tag[r_set]   <= n_tag;
            mem_age[r_set]   <= n_age;
            mem_reuse[r_set] <= n_reuse;
            mem_valid[r_set] <= n_valid;
            mem_full[r_set]  <= n_full;
        end
        if (w_rd) begin
            r_set      <= i_q_set;
            r_tag      <= i_q_tag;
            r_rd_tag   <= mem_tag[i_q_set];
            r_rd_age   <= mem_age[i_q_set];
            r_rd_reuse <= mem_reuse[i_q_set];
            r_rd_valid <= mem_valid[i_q_set];
            r_rd_full  <= mem_full[i_q_set];
        end
    end

endmodule

FILE: hw/rtl/lip_set_assoc_tag_store.sv
// ----------------------------------------------------------------------------
// lip_set_assoc_tag_store
// set-associative tag store with lru insertion policy and reuse histogram
// ----------------------------------------------------------------------------
// One address word in gives one result word out. For each access the set
// unit reads the set row from the tag memory, then updates and writes it
// back, and takes no new word before the write-back, which waits while the
// result register holds an untaken word. A two-word queue decouples the
// input from the set unit and a result register decouples it from the
// output. After reset a clearing pass walks the tag memory one set per cycle
// (2**SET_BITS sets, 64 by default); no address word is taken before it ends.
module lip_set_assoc_tag_store import lsats_pkg::*; #(
    parameter int WAYS        = WAYS_DEF,
    parameter int SET_BITS    = SET_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [ADDR_W-1:0] i_s_tdata,   // address
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [RES_W-1:0]  o_m_tdata    // hit, way, victim_was_valid, victim_reuse,
                                           // bucket_total, hit_total, miss_total
);

    localparam int AEFF  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TRAW  = AEFF - OFFSET_BITS - SET_BITS;
    localparam int TAG_W = (TRAW < 1) ? 1 : TRAW;

    t_q_ctl              w_ctl;
    logic                w_q_valid;
    logic [SET_BITS-1:0] w_q_set;
    logic [TAG_W-1:0]    w_q_tag;

    // address split and queue
    lsats_front #(
        .SET_BITS    (SET_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .TAG_W       (TAG_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_ctl      (w_ctl),
        .o_q_valid  (w_q_valid),
        .o_q_set    (w_q_set),
        .o_q_tag    (w_q_tag)
    );

    // set read-modify-write
    lsats_back #(
        .WAYS     (WAYS),
        .SET_BITS (SET_BITS),
        .TAG_W    (TAG_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_set    (w_q_set),
        .i_q_tag    (w_q_tag),
        .o_ctl      (w_ctl),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // a hit never evicts
    a_hit_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[4]))
        else $error("hit word reports an evicted line");

    // no bucket total without a valid victim
    a_bucket_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[4]) |-> (o_m_tdata[40:5] == 36'd0))
        else $error("bucket total without valid victim");

    // no word taken while the tag memory is being cleared
    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clr_busy |-> (!o_s_tready && !w_ctl.pop))
        else $error("access taken during clearing pass");

endmodule
